[design/rpp_pkg.sv]
package rpp_pkg;

   localparam int unsigned VERSION_W = 16;
   localparam int unsigned INDEX_W   = 17;
   localparam int unsigned CSR_W     = 17;

   // configuration register indexes
   localparam logic CSR_EXPECTED_VERSION = 1'b0;
   localparam logic CSR_ARG_LIMIT        = 1'b1;

   localparam logic [VERSION_W-1:0] EXPECTED_VERSION_RESET = 16'd1;
   localparam logic [INDEX_W-1:0]   ARG_LIMIT_RESET        = 17'd65536;

   // result kinds
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_EMPTY  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK               = 3'd0;
   localparam logic [2:0] ST_SHORT_VERSION    = 3'd1;
   localparam logic [2:0] ST_VERSION_MISMATCH = 3'd2;
   localparam logic [2:0] ST_NO_COUNT         = 3'd3;
   localparam logic [2:0] ST_COUNT_TOO_LARGE  = 3'd4;
   localparam logic [2:0] ST_BAD_ARGUMENT     = 3'd5;
   localparam logic [2:0] ST_MISSING_WORKDIR  = 3'd6;
   localparam logic [2:0] ST_TRAILING_BYTES   = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_payload;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [INDEX_W-1:0] arg_index;
      logic               is_workdir;
      logic [7:0]         string_byte;
      logic               string_end;
      logic [2:0]         status;
      logic               last;
   } rsp_payload_type;

endpackage

[design/rpp_ifs.sv]
interface rpp_req_if;
   import rpp_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rpp_rsp_if;
   import rpp_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/request_payload_parser.sv]
// Request payload parser.
// req_if carries one payload byte per request (data_byte with has_byte), or
// a bare end marker; end_of_payload closes the payload. rsp_if returns string
// bytes tagged with their string index, empty-string markers, and one final
// status result per payload (0 when valid, else an error code).
// csr_we/csr_index/csr_wdata write expected_version (index 0) and arg_limit
// (index 1); write them only while the block is idle.
// Throughput: one request per cycle while req_if.ready is high. Each request is
// parsed in the cycle it is accepted and its zero, one or two results are
// registered into a 4-entry result queue that feeds rsp_if in order.
// req_if.ready stays high while the queue has room for two results, since a
// request with a byte and an end marker pushes two results.
// If rsp_if stalls, req_if.ready drops once three or more results wait in the
// queue; requests that make no result are held as well. Nothing is dropped.
// Reset (synchronous) empties the queue, returns the parser to the version
// field and sets expected_version to 1 and arg_limit to 65536.
module request_payload_parser (
   input  logic                         clock,
   input  logic                         reset,
   rpp_req_if.sink                      req_if,
   rpp_rsp_if.source                    rsp_if,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [rpp_pkg::CSR_W-1:0]    csr_wdata
);
   import rpp_pkg::*;

   typedef enum logic [2:0] {
      PH_VERSION,
      PH_COUNT,
      PH_ARGLEN,
      PH_ARGBYTES,
      PH_WDLEN,
      PH_WDBYTES,
      PH_DONE
   } phase_type;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   logic [VERSION_W-1:0] expected_version_ff;
   logic [INDEX_W-1:0]   arg_limit_ff;

   phase_type            phase_ff, phase_in;
   logic [1:0]           field_cnt_ff, field_cnt_in;
   logic [23:0]          acc_ff, acc_in;
   logic [INDEX_W-1:0]   arg_count_ff, arg_count_in;
   logic [INDEX_W-1:0]   cur_string_ff, cur_string_in;
   logic [31:0]          bytes_left_ff, bytes_left_in;
   logic [2:0]           error_ff, error_in;

   rsp_payload_type      queue_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]    q_cnt_ff;

   logic                 accept;
   logic                 take;
   logic                 is_end;
   logic [31:0]          field_val;
   logic                 wd;
   logic                 finish;
   logic [INDEX_W-1:0]   next_string;
   logic                 byte_res_valid;
   rsp_payload_type      byte_res;
   rsp_payload_type      status_res;
   logic [2:0]           final_status;
   rsp_payload_type      res0, res1;
   logic [1:0]           push_cnt;
   logic                 pop;

   assign req_if.ready = (q_cnt_ff <= QCNT_W'(QDEPTH - 2));
   assign accept       = req_if.valid && req_if.ready;
   assign take         = accept && req_if.payload.has_byte && (error_ff == ST_OK);
   assign is_end       = accept && req_if.payload.end_of_payload;
   assign field_val    = {acc_ff, req_if.payload.data_byte};
   assign next_string  = cur_string_ff + INDEX_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      field_cnt_in   = field_cnt_ff;
      acc_in         = acc_ff;
      arg_count_in   = arg_count_ff;
      cur_string_in  = cur_string_ff;
      bytes_left_in  = bytes_left_ff;
      error_in       = error_ff;
      wd             = 1'b0;
      finish         = 1'b0;
      byte_res_valid = 1'b0;
      byte_res       = '0;

      if (take) begin
         case (phase_ff)
            PH_VERSION: begin
               if (field_cnt_ff != 2'd0) begin
                  if (field_val[15:0] != expected_version_ff) begin
                     error_in = ST_VERSION_MISMATCH;
                  end else begin
                     phase_in = PH_COUNT;
                  end
                  field_cnt_in = 2'd0;
                  acc_in       = '0;
               end else begin
                  field_cnt_in = field_cnt_ff + 2'd1;
                  acc_in       = field_val[23:0];
               end
            end
            PH_COUNT, PH_ARGLEN, PH_WDLEN: begin
               if (field_cnt_ff != 2'd3) begin
                  field_cnt_in = field_cnt_ff + 2'd1;
                  acc_in       = field_val[23:0];
               end else begin
                  field_cnt_in = 2'd0;
                  acc_in       = '0;
                  if (phase_ff == PH_COUNT) begin
                     // full 32-bit count against the limit
                     if (field_val > {15'd0, arg_limit_ff}) begin
                        error_in = ST_COUNT_TOO_LARGE;
                     end else begin
                        arg_count_in  = field_val[INDEX_W-1:0];
                        cur_string_in = '0;
                        phase_in      = (field_val == 32'd0) ? PH_WDLEN : PH_ARGLEN;
                     end
                  end else begin
                     wd = (phase_ff == PH_WDLEN);
                     if (field_val == 32'd0) begin
                        byte_res_valid       = 1'b1;
                        byte_res.kind        = KIND_EMPTY;
                        byte_res.arg_index   = cur_string_ff;
                        byte_res.is_workdir  = wd;
                        byte_res.string_end  = 1'b1;
                        finish               = 1'b1;
                     end else begin
                        bytes_left_in = field_val;
                        phase_in      = wd ? PH_WDBYTES : PH_ARGBYTES;
                     end
                  end
               end
            end
            PH_ARGBYTES, PH_WDBYTES: begin
               wd                   = (phase_ff == PH_WDBYTES);
               bytes_left_in        = bytes_left_ff - 32'd1;
               byte_res_valid       = 1'b1;
               byte_res.kind        = KIND_BYTE;
               byte_res.arg_index   = cur_string_ff;
               byte_res.is_workdir  = wd;
               byte_res.string_byte = req_if.payload.data_byte;
               byte_res.string_end  = (bytes_left_ff == 32'd1);
               finish               = (bytes_left_ff == 32'd1);
            end
            default: begin
               error_in = ST_TRAILING_BYTES;
            end
         endcase

         if (finish) begin
            if (wd) begin
               phase_in = PH_DONE;
            end else begin
               cur_string_in = next_string;
               phase_in      = (next_string >= arg_count_ff) ? PH_WDLEN : PH_ARGLEN;
            end
         end
      end

      // status follows from the state left after this request's byte
      if (error_in != ST_OK) begin
         final_status = error_in;
      end else begin
         case (phase_in)
            PH_VERSION:              final_status = ST_SHORT_VERSION;
            PH_COUNT:                final_status = ST_NO_COUNT;
            PH_ARGLEN, PH_ARGBYTES:  final_status = ST_BAD_ARGUMENT;
            PH_WDLEN, PH_WDBYTES:    final_status = ST_MISSING_WORKDIR;
            default:                 final_status = ST_OK;
         endcase
      end

      if (is_end) begin
         phase_in      = PH_VERSION;
         field_cnt_in  = 2'd0;
         acc_in        = '0;
         arg_count_in  = '0;
         cur_string_in = '0;
         bytes_left_in = '0;
         error_in      = ST_OK;
      end
   end

   always_comb begin
      status_res        = '0;
      status_res.kind   = KIND_STATUS;
      status_res.status = final_status;
      status_res.last   = 1'b1;

      res0 = byte_res;
      res1 = status_res;
      if (byte_res_valid && is_end) begin
         push_cnt = 2'd2;
      end else if (byte_res_valid) begin
         res0.last = 1'b1;
         push_cnt  = 2'd1;
      end else if (is_end) begin
         res0     = status_res;
         push_cnt = 2'd1;
      end else begin
         push_cnt = 2'd0;
      end
   end

   assign rsp_if.valid   = (q_cnt_ff != '0);
   assign rsp_if.payload = queue_ff[rd_ptr_ff];
   assign pop            = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= EXPECTED_VERSION_RESET;
         arg_limit_ff        <= ARG_LIMIT_RESET;
         phase_ff            <= PH_VERSION;
         field_cnt_ff        <= 2'd0;
         acc_ff              <= '0;
         arg_count_ff        <= '0;
         cur_string_ff       <= '0;
         bytes_left_ff       <= '0;
         error_ff            <= ST_OK;
         wr_ptr_ff           <= '0;
         rd_ptr_ff           <= '0;
         q_cnt_ff            <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_EXPECTED_VERSION: expected_version_ff <= csr_wdata[VERSION_W-1:0];
               CSR_ARG_LIMIT:        arg_limit_ff        <= csr_wdata[INDEX_W-1:0];
               default:              ;
            endcase
         end
         phase_ff      <= phase_in;
         field_cnt_ff  <= field_cnt_in;
         acc_ff        <= acc_in;
         arg_count_ff  <= arg_count_in;
         cur_string_ff <= cur_string_in;
         bytes_left_ff <= bytes_left_in;
         error_ff      <= error_in;
         wr_ptr_ff     <= wr_ptr_ff + QPTR_W'(push_cnt);
         rd_ptr_ff     <= rd_ptr_ff + QPTR_W'(pop);
         q_cnt_ff      <= q_cnt_ff + QCNT_W'(push_cnt) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= res1;
      end
   end

endmodule

[tb/tb_request_payload_parser.sv]
`timescale 1ns / 1ps

module tb_request_payload_parser;
   import rpp_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_ITEMS   = 95;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [2:0] {
      P_VERSION, P_COUNT, P_ARGLEN, P_ARGBYTES, P_WDLEN, P_WDBYTES, P_DONE
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       eop;
      logic       typed;   // status below is known by inspection
      logic [2:0] st;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [0:22] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, ST_SHORT_VERSION},    // bare end on empty payload
      '{8'h5A, 1'b0, 1'b0, 1'b0, ST_OK},               // no byte, no end
      '{8'hFF, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b1, 1'b1, 1'b1, ST_VERSION_MISMATCH},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h01, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b1, 1'b1, ST_NO_COUNT},         // count cut short
      // version 1, count 1, empty arg, 1-byte workdir, then a stray byte
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h01, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h01, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h01, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h80, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b1, 1'b1, ST_TRAILING_BYTES}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic csr_index;
   logic [CSR_W-1:0] csr_wdata;

   rpp_req_if req_if ();
   rpp_rsp_if rsp_if ();

   request_payload_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // parser state as the block should hold it
   parse_phase_type      p_phase;
   logic [1:0]           p_field_cnt;
   logic [31:0]          p_field_acc;
   logic [INDEX_W-1:0]   p_nargs;
   logic [INDEX_W-1:0]   p_str_idx;
   logic [31:0]          p_bytes_left;
   logic [2:0]           p_error;
   logic [VERSION_W-1:0] cfg_version;
   logic [INDEX_W-1:0]   cfg_limit;

   rsp_payload_type parser_outputs [$];
   req_payload_type payload_q [$];
   int              mismatches = 0;
   int              cycle_count = 0;
   int              burst_left = 0;

   // receiver stall pattern, reshuffled whenever its countdown runs out
   int          stall_mode = 0;
   int          stall_cnt = 0;
   logic [31:0] stall_pat = '1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_cnt == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_pat  <= $urandom;
         stall_cnt  <= 48;
      end else begin
         stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= stall_pat[stall_cnt[4:0]];
         default: rsp_if.ready <= (stall_cnt[2:0] == 3'd0);
      endcase
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp);
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, exp);
      mismatches++;
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type exp;
      if (parser_outputs.size() == 0) begin
         report_mismatch("unexpected result, kind", 32'(got.kind), '0);
      end else begin
         exp = parser_outputs.pop_front();
         if (got.kind != exp.kind)
            report_mismatch("kind", 32'(got.kind), 32'(exp.kind));
         if (got.arg_index != exp.arg_index)
            report_mismatch("arg_index", 32'(got.arg_index), 32'(exp.arg_index));
         if (got.is_workdir != exp.is_workdir)
            report_mismatch("is_workdir", 32'(got.is_workdir), 32'(exp.is_workdir));
         if (got.string_byte != exp.string_byte)
            report_mismatch("string_byte", 32'(got.string_byte), 32'(exp.string_byte));
         if (got.string_end != exp.string_end)
            report_mismatch("string_end", 32'(got.string_end), 32'(exp.string_end));
         if (got.status != exp.status)
            report_mismatch("status", 32'(got.status), 32'(exp.status));
         if (got.last != exp.last)
            report_mismatch("last", 32'(got.last), 32'(exp.last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         check_result(rsp_if.payload);
   end

   function automatic void clear_parse();
      p_phase      = P_VERSION;
      p_field_cnt  = '0;
      p_field_acc  = '0;
      p_nargs      = '0;
      p_str_idx    = '0;
      p_bytes_left = '0;
      p_error      = ST_OK;
   endfunction

   function automatic rsp_payload_type make_result(input logic [1:0] kind,
         input logic [INDEX_W-1:0] idx, input logic wd, input logic [7:0] b,
         input logic str_end, input logic [2:0] st);
      rsp_payload_type r;
      r.kind        = kind;
      r.arg_index   = idx;
      r.is_workdir  = wd;
      r.string_byte = b;
      r.string_end  = str_end;
      r.status      = st;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic void close_string(input logic wd);
      if (wd) begin
         p_phase = P_DONE;
      end else begin
         p_str_idx = p_str_idx + 1'b1;
         p_phase   = (p_str_idx >= p_nargs) ? P_WDLEN : P_ARGLEN;
      end
   endfunction

   function automatic logic [2:0] end_status();
      if (p_error != ST_OK)
         return p_error;
      case (p_phase)
         P_VERSION:            return ST_SHORT_VERSION;
         P_COUNT:              return ST_NO_COUNT;
         P_ARGLEN, P_ARGBYTES: return ST_BAD_ARGUMENT;
         P_WDLEN, P_WDBYTES:   return ST_MISSING_WORKDIR;
         default:              return ST_OK;
      endcase
   endfunction

   // advance the parser by one request and queue the results it causes
   function automatic void parse_request(input req_payload_type it);
      rsp_payload_type res [$];
      logic [31:0]     acc;
      logic            wd;
      if (it.has_byte && p_error == ST_OK) begin
         case (p_phase)
            P_VERSION: begin
               acc = {p_field_acc[23:0], it.data_byte};
               if (p_field_cnt >= 2'd1) begin
                  if (acc[15:0] != cfg_version)
                     p_error = ST_VERSION_MISMATCH;
                  else
                     p_phase = P_COUNT;
                  p_field_cnt = '0;
                  p_field_acc = '0;
               end else begin
                  p_field_cnt++;
                  p_field_acc = acc;
               end
            end
            P_COUNT, P_ARGLEN, P_WDLEN: begin
               acc = {p_field_acc[23:0], it.data_byte};
               if (p_field_cnt < 2'd3) begin
                  p_field_cnt++;
                  p_field_acc = acc;
               end else begin
                  p_field_cnt = '0;
                  p_field_acc = '0;
                  if (p_phase == P_COUNT) begin
                     // full 32-bit count against the limit
                     if (acc > {15'd0, cfg_limit}) begin
                        p_error = ST_COUNT_TOO_LARGE;
                     end else begin
                        p_nargs   = acc[INDEX_W-1:0];
                        p_str_idx = '0;
                        p_phase   = (acc == 0) ? P_WDLEN : P_ARGLEN;
                     end
                  end else begin
                     wd = (p_phase == P_WDLEN);
                     if (acc == 0) begin
                        res.push_back(make_result(KIND_EMPTY, p_str_idx, wd, 8'h00, 1'b1,
                                                  ST_OK));
                        close_string(wd);
                     end else begin
                        p_bytes_left = acc;
                        p_phase      = wd ? P_WDBYTES : P_ARGBYTES;
                     end
                  end
               end
            end
            P_ARGBYTES, P_WDBYTES: begin
               wd = (p_phase == P_WDBYTES);
               p_bytes_left--;
               res.push_back(make_result(KIND_BYTE, p_str_idx, wd, it.data_byte,
                                         p_bytes_left == 0, ST_OK));
               if (p_bytes_left == 0)
                  close_string(wd);
            end
            default: p_error = ST_TRAILING_BYTES;
         endcase
      end
      if (it.end_of_payload) begin
         res.push_back(make_result(KIND_STATUS, '0, 1'b0, 8'h00, 1'b0, end_status()));
         res[res.size()-1].last = 1'b1;
         clear_parse();
      end else if (res.size() > 0) begin
         res[res.size()-1].last = 1'b1;
      end
      foreach (res[i])
         parser_outputs.push_back(res[i]);
   endfunction

   task automatic send_request(input req_payload_type it);
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      parse_request(it);
   endtask

   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         req_if.valid   <= 1'b0;
         req_if.payload <= 10'($urandom);
      end
   endtask

   // bursts of requests with random gaps, plus an occasional ignored request
   task automatic issue(input req_payload_type it);
      req_payload_type idle_req;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0)
            hold_off($urandom_range(1, 6));
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      if ($urandom_range(0, 24) == 0) begin
         idle_req = '{data_byte: 8'($urandom), has_byte: 1'b0, end_of_payload: 1'b0};
         send_request(idle_req);
      end
      send_request(it);
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (parser_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_EXPECTED_VERSION)
         cfg_version = value[VERSION_W-1:0];
      else
         cfg_limit = value[INDEX_W-1:0];
   endtask

   function automatic void add_byte(input logic [7:0] b);
      payload_q.push_back('{data_byte: b, has_byte: 1'b1, end_of_payload: 1'b0});
   endfunction

   function automatic void add_field(input logic [31:0] v, input int nb);
      for (int k = nb - 1; k >= 0; k--)
         add_byte(v[8*k +: 8]);
   endfunction

   // one payload: mostly well formed, the rest damaged in various ways
   task automatic build_payload();
      int          mode;
      int          n_build;
      int          len;
      logic [31:0] cnt;
      mode = $urandom_range(0, 99);
      payload_q.delete();
      if (mode < 6) begin
         repeat ($urandom_range(0, 10)) add_byte(8'($urandom));
      end else begin
         if (mode < 12)
            add_field(cfg_version ^ (16'd1 << $urandom_range(0, 15)), 2);
         else
            add_field(cfg_version, 2);
         if (mode >= 12 && mode < 18)
            cnt = $urandom_range(0, 1) ? {1'b1, 31'($urandom)} : cfg_limit + $urandom_range(1, 3);
         else if (mode >= 18 && mode < 24)
            cnt = cfg_limit;
         else
            cnt = $urandom_range(0, (cfg_limit < 4) ? int'(cfg_limit) : 4);
         add_field(cnt, 4);
         n_build = (cnt > 4) ? 4 : int'(cnt);
         for (int i = 0; i < n_build; i++) begin
            len = $urandom_range(0, 4);
            add_field(len, 4);
            repeat (len) add_byte(8'($urandom));
         end
         if (cnt <= 4) begin
            len = $urandom_range(0, 5);
            add_field(len, 4);
            repeat (len) add_byte(8'($urandom));
         end
         if (mode >= 24 && mode < 32)
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
         else if (mode >= 32 && mode < 44)
            repeat ($urandom_range(1, payload_q.size())) void'(payload_q.pop_back());
      end
      if (payload_q.size() > 0 && $urandom_range(0, 1) == 1)
         payload_q[payload_q.size()-1].end_of_payload = 1'b1;
      else
         payload_q.push_back('{data_byte: 8'($urandom), has_byte: 1'b0, end_of_payload: 1'b1});
   endtask

   initial begin
      req_payload_type it;
      int              sent;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_EXPECTED_VERSION;
      csr_wdata      = '0;
      cfg_version    = EXPECTED_VERSION_RESET;
      cfg_limit      = ARG_LIMIT_RESET;
      clear_parse();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         it = '{data_byte: DIRECTED_ROWS[i].data, has_byte: DIRECTED_ROWS[i].has,
                end_of_payload: DIRECTED_ROWS[i].eop};
         issue(it);
         if (DIRECTED_ROWS[i].typed)
            parser_outputs[parser_outputs.size()-1].status = DIRECTED_ROWS[i].st;
      end

      for (int phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            0: begin
               write_csr(CSR_EXPECTED_VERSION, 17'h0FFFF);
               write_csr(CSR_ARG_LIMIT, 17'd0);
            end
            1: begin
               write_csr(CSR_EXPECTED_VERSION, 17'd0);
               write_csr(CSR_ARG_LIMIT, 17'd65536);
            end
            2: begin
               write_csr(CSR_EXPECTED_VERSION, 17'($urandom_range(0, 65535)));
               write_csr(CSR_ARG_LIMIT, 17'($urandom_range(1, 6)));
            end
            3: begin
               write_csr(CSR_EXPECTED_VERSION, 17'($urandom_range(0, 65535)));
               write_csr(CSR_ARG_LIMIT, 17'($urandom_range(0, 65536)));
            end
            default: begin
               write_csr(CSR_EXPECTED_VERSION, 17'd1);
               write_csr(CSR_ARG_LIMIT, 17'd3);
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_payload();
            while (payload_q.size() != 0) begin
               issue(payload_q.pop_front());
               sent++;
            end
         end
      end

      settle();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
